[hw/rtl/sha256_pkg.sv]
// Shared types, constants and functions of the SHA-256 byte stream hasher.
// Used by the top level and the compression core; depends on nothing else.
`default_nettype none

package sha256_pkg;

   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned LenOffset   = 56;
   localparam int unsigned DigestWords = 8;
   localparam logic [7:0]  PadMarker   = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_PAD,
      ST_PAD_COMPRESS,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic init;
      logic start;
      logic shift;
   } core_ctrl_type;

   typedef struct packed {
      logic done;
   } core_stat_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      logic [63:0] both;
      both = {x, x} >> n;
      return both[31:0];
   endfunction

   function automatic logic [31:0] big0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] hash_init(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         3'd7: v = 32'h5be0cd19;
         default: v = 32'h6a09e667;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] v;
      case (idx)
         6'd0:  v = 32'h428a2f98;
         6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;
         6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;
         6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;
         6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;
         6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;
         6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;
         6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;
         6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;
         6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;
         6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;
         6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;
         6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;
         6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;
         6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;
         6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;
         6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;
         6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;
         6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;
         6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;
         6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;
         6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;
         6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;
         6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;
         6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;
         6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;
         6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;
         6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;
         6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;
         6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;
         6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;
         6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;
         6'd63: v = 32'hc67178f2;
         default: v = 32'h428a2f98;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/sha256_byte_stream_hasher.sv]
// Top level of the SHA-256 byte stream hasher: message sequencer, padding and
// digest output. Uses sha256_pkg and instantiates sha256_core.
//
//   Channel | Direction | Word contents
//   req     | in        | tdata message byte, tuser byte present, tlast end of message
//   rsp     | out       | tdata digest word, tuser word index, tlast eighth word
//
// The 64th byte of a block starts the compression, which runs one round per cycle
// through the single round unit. The end of a message adds the padding bytes,
// one or two compressions, and eight output words that each wait for rsp_tready.
// Input is not taken while a block is compressed, padded or the digest is read out.
// Reset is synchronous and leaves the block ready for a new message.
`default_nettype none

module sha256_byte_stream_hasher import sha256_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   state_type     state_ff, state_in;
   logic [5:0]    count_ff, count_in;
   logic [63:0]   bits_ff, bits_in;
   logic          pend_ff, pend_in;
   logic          first_ff, first_in;
   logic          lenblk_ff, lenblk_in;
   logic [2:0]    index_ff, index_in;

   core_ctrl_type ctrl;
   core_stat_type stat;
   logic [7:0]    shift_byte;
   logic [7:0]    pad_byte;
   logic [2:0]    len_sel;
   logic [31:0]   rd_word;
   logic          req_take, rsp_take;

   sha256_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .shift_byte (shift_byte),
      .rd_index   (index_ff),
      .stat       (stat),
      .rd_word    (rd_word)
   );

   always_comb begin
      len_sel = ~count_ff[2:0];
      if (first_ff) begin
         pad_byte = PadMarker;
      end else if (lenblk_ff && (count_ff >= 6'(LenOffset))) begin
         pad_byte = bits_ff[8*len_sel +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      bits_in    = bits_ff;
      pend_in    = pend_ff;
      first_in   = first_ff;
      lenblk_in  = lenblk_ff;
      index_in   = index_ff;
      ctrl       = '0;
      shift_byte = req_tdata;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      req_take   = 1'b0;
      rsp_take   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            req_take   = req_tvalid;
            if (req_take) begin
               if (req_tlast) begin
                  first_in  = 1'b1;
                  lenblk_in = 1'b0;
               end
               if (req_tuser) begin
                  ctrl.shift = 1'b1;
                  count_in   = count_ff + 6'd1;
                  bits_in    = bits_ff + 64'd8;
                  if (count_ff == 6'(BlockBytes - 1)) begin
                     ctrl.start = 1'b1;
                     pend_in    = req_tlast;
                     state_in   = ST_COMPRESS;
                  end else if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMPRESS: begin
            if (stat.done) begin
               state_in = pend_ff ? ST_PAD : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_PAD: begin
            ctrl.shift = 1'b1;
            shift_byte = pad_byte;
            count_in   = count_ff + 6'd1;
            first_in   = 1'b0;
            if (first_ff && (count_ff < 6'(LenOffset))) begin
               lenblk_in = 1'b1;
            end
            if (count_ff == 6'(BlockBytes - 1)) begin
               ctrl.start = 1'b1;
               state_in   = ST_PAD_COMPRESS;
            end
         end
         ST_PAD_COMPRESS: begin
            if (stat.done) begin
               if (lenblk_ff) begin
                  index_in = '0;
                  state_in = ST_OUTPUT;
               end else begin
                  lenblk_in = 1'b1;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_OUTPUT: begin
            rsp_tvalid = 1'b1;
            rsp_take   = rsp_tready;
            if (rsp_take) begin
               index_in = index_ff + 3'd1;
               if (index_ff == 3'(DigestWords - 1)) begin
                  ctrl.init = 1'b1;
                  count_in  = '0;
                  bits_in   = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         bits_ff   <= '0;
         pend_ff   <= 1'b0;
         first_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
         index_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bits_ff   <= bits_in;
         pend_ff   <= pend_in;
         first_ff  <= first_in;
         lenblk_ff <= lenblk_in;
         index_ff  <= index_in;
      end
   end

   assign rsp_tdata = rd_word;
   assign rsp_tuser = index_ff;
   assign rsp_tlast = (index_ff == 3'(DigestWords - 1));

endmodule

`default_nettype wire

[hw/rtl/sha256_core.sv]
// SHA-256 compression core: a 16-word schedule window that doubles as the byte
// buffer, the hash state, and one round unit reused for every round. Uses sha256_pkg.
`default_nettype none

module sha256_core import sha256_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   input  logic [7:0]    shift_byte,
   input  logic [2:0]    rd_index,
   output core_stat_type stat,
   output logic [31:0]   rd_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [5:0]  round_ff, round_in;
   logic        run_ff, run_in;
   logic        add_ff, add_in;

   logic [31:0] ch, maj, t1, t2, sched_new;

   always_comb begin
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
            (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + big1(work_ff[4]) + ch + round_k(round_ff) + sched_ff[0];
      t2  = big0(work_ff[0]) + maj;
      sched_new = small1(sched_ff[14]) + sched_ff[9] + small0(sched_ff[1]) + sched_ff[0];
   end

   always_comb begin
      hash_in  = hash_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      run_in   = run_ff;
      add_in   = 1'b0;

      if (ctrl.shift) begin
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_in[15] = {sched_ff[15][23:0], shift_byte};
      end else if (run_ff) begin
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[15] = sched_new;
      end

      if (ctrl.start) begin
         work_in  = hash_ff;
         round_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         round_in   = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end

      if (add_ff) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (ctrl.init) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_init(3'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_init(3'(i));
         end
         round_ff <= '0;
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         round_ff <= round_in;
         run_ff   <= run_in;
         add_ff   <= add_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign stat.done = add_ff;
   assign rd_word   = hash_ff[rd_index];

endmodule

`default_nettype wire

[hw/rtl/sha256_checker.sv]
// Port-level checks of the SHA-256 byte stream hasher, attached by a bind
// statement to sha256_byte_stream_hasher. No package is needed.
`default_nettype none

module sha256_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire [2:0]  rsp_tuser,
   input wire        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled digest word changed.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Input taken while digest is being read out.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd7)))
      else $error("Last flag does not match the eighth word.");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == 3'($past(rsp_tuser) + 3'd1)))
      else $error("Digest words not delivered in order.");

   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("Block not ready for a new message after the digest.");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (.*);

`default_nettype wire
